// ===== rtl/spdv_pkg.sv =====
// spdv_pkg: constant tables and fixed constants for the stereo pan and distance volume block
// no dependencies; imported by stereo_pan_distance_volume
`timescale 1ns / 1ps
`default_nettype none

package spdv_pkg;

    // one output volume
    typedef logic [6:0] t_vol;

    // level of the near channel, and of both channels when centred
    localparam logic [7:0] NEAR_LEVEL = 8'h89;
    // distance step per attenuation entry
    localparam int unsigned DIST_STEP = 250;
    // fraction bits of the bearing ratio, and its value for one
    localparam int unsigned FRAC_BITS = 12;
    localparam int unsigned UNITY     = 4096;
    // numerator 2^24 of the reciprocal ratio needs 25 bits
    localparam int unsigned RECIP_BITS = 25;
    // arctangent of a ratio of exactly one
    localparam logic [9:0] ATAN_TOP = 10'd512;

    // pan curve (entries 0..127) followed by the attenuation curve (128..255)
    localparam logic [7:0] VOL_ROM [256] = '{
        8'h7f,8'h7f,8'h7f,8'h7f,8'h7f,8'h7f,8'h7f,8'h7f,
        8'h7f,8'h7f,8'h7f,8'h7f,8'h7f,8'h7f,8'h7f,8'h7f,
        8'h7e,8'h7e,8'h7e,8'h7e,8'h7d,8'h7d,8'h7d,8'h7d,
        8'h7c,8'h7c,8'h7c,8'h7c,8'h7b,8'h7b,8'h7a,8'h7a,
        8'h79,8'h79,8'h78,8'h78,8'h77,8'h77,8'h76,8'h76,
        8'h75,8'h75,8'h74,8'h74,8'h74,8'h74,8'h73,8'h73,
        8'h72,8'h72,8'h71,8'h71,8'h70,8'h70,8'h6f,8'h6f,
        8'h6e,8'h6e,8'h6d,8'h6d,8'h6c,8'h6c,8'h6b,8'h6b,
        8'h6a,8'h6a,8'h69,8'h69,8'h68,8'h68,8'h67,8'h67,
        8'h66,8'h66,8'h65,8'h65,8'h64,8'h64,8'h63,8'h63,
        8'h62,8'h62,8'h61,8'h61,8'h60,8'h60,8'h5f,8'h5f,
        8'h5e,8'h5e,8'h5d,8'h5d,8'h5c,8'h5c,8'h5b,8'h5b,
        8'h5a,8'h5a,8'h59,8'h58,8'h57,8'h56,8'h55,8'h54,
        8'h53,8'h52,8'h51,8'h50,8'h4f,8'h4e,8'h4d,8'h4c,
        8'h4b,8'h4a,8'h49,8'h48,8'h47,8'h46,8'h45,8'h44,
        8'h43,8'h42,8'h41,8'h40,8'h3f,8'h3e,8'h3d,8'h3c,
        8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h0a,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,
        8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,
        8'h18,8'h19,8'h1a,8'h1a,8'h1b,8'h1b,8'h1c,8'h1c,
        8'h1d,8'h1d,8'h1e,8'h1e,8'h1f,8'h1f,8'h20,8'h20,
        8'h21,8'h21,8'h22,8'h22,8'h23,8'h23,8'h24,8'h24,
        8'h25,8'h25,8'h26,8'h26,8'h27,8'h27,8'h28,8'h28,
        8'h29,8'h29,8'h2a,8'h2a,8'h2b,8'h2b,8'h2c,8'h2c,
        8'h2d,8'h2d,8'h2e,8'h2e,8'h2f,8'h2f,8'h30,8'h30,
        8'h31,8'h31,8'h32,8'h32,8'h33,8'h33,8'h34,8'h34,
        8'h35,8'h35,8'h36,8'h36,8'h37,8'h37,8'h38,8'h38,
        8'h39,8'h39,8'h3a,8'h3a,8'h3b,8'h3b,8'h3c,8'h3c,
        8'h3d,8'h3d,8'h3e,8'h3e,8'h3f,8'h3f,8'h40,8'h40,
        8'h41,8'h41,8'h42,8'h42,8'h43,8'h43,8'h44,8'h44,
        8'h45,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h4b,
        8'h4c,8'h4d,8'h4e,8'h4f,8'h50,8'h51,8'h52,8'h53
    };

    // arctangent of k/256 for k = 0..255, 4096 units per turn
    localparam logic [9:0] ATAN_ROM [256] = '{
        10'd0,  10'd3,  10'd5,  10'd8,  10'd10, 10'd13, 10'd15, 10'd18,
        10'd20, 10'd23, 10'd25, 10'd28, 10'd31, 10'd33, 10'd36, 10'd38,
        10'd41, 10'd43, 10'd46, 10'd48, 10'd51, 10'd53, 10'd56, 10'd58,
        10'd61, 10'd63, 10'd66, 10'd69, 10'd71, 10'd74, 10'd76, 10'd79,
        10'd81, 10'd84, 10'd86, 10'd89, 10'd91, 10'd94, 10'd96, 10'd99,
        10'd101,10'd104,10'd106,10'd108,10'd111,10'd113,10'd116,10'd118,
        10'd121,10'd123,10'd126,10'd128,10'd131,10'd133,10'd136,10'd138,
        10'd140,10'd143,10'd145,10'd148,10'd150,10'd152,10'd155,10'd157,
        10'd160,10'd162,10'd164,10'd167,10'd169,10'd172,10'd174,10'd176,
        10'd179,10'd181,10'd183,10'd186,10'd188,10'd190,10'd193,10'd195,
        10'd197,10'd200,10'd202,10'd204,10'd207,10'd209,10'd211,10'd214,
        10'd216,10'd218,10'd220,10'd223,10'd225,10'd227,10'd229,10'd232,
        10'd234,10'd236,10'd238,10'd241,10'd243,10'd245,10'd247,10'd249,
        10'd252,10'd254,10'd256,10'd258,10'd260,10'd262,10'd265,10'd267,
        10'd269,10'd271,10'd273,10'd275,10'd277,10'd279,10'd282,10'd284,
        10'd286,10'd288,10'd290,10'd292,10'd294,10'd296,10'd298,10'd300,
        10'd302,10'd304,10'd306,10'd308,10'd310,10'd312,10'd314,10'd316,
        10'd318,10'd320,10'd322,10'd324,10'd326,10'd328,10'd330,10'd332,
        10'd334,10'd336,10'd338,10'd340,10'd342,10'd344,10'd346,10'd347,
        10'd349,10'd351,10'd353,10'd355,10'd357,10'd359,10'd360,10'd362,
        10'd364,10'd366,10'd368,10'd370,10'd371,10'd373,10'd375,10'd377,
        10'd379,10'd380,10'd382,10'd384,10'd386,10'd387,10'd389,10'd391,
        10'd393,10'd394,10'd396,10'd398,10'd399,10'd401,10'd403,10'd405,
        10'd406,10'd408,10'd410,10'd411,10'd413,10'd415,10'd416,10'd418,
        10'd419,10'd421,10'd423,10'd424,10'd426,10'd428,10'd429,10'd431,
        10'd432,10'd434,10'd435,10'd437,10'd439,10'd440,10'd442,10'd443,
        10'd445,10'd446,10'd448,10'd449,10'd451,10'd452,10'd454,10'd455,
        10'd457,10'd458,10'd460,10'd461,10'd463,10'd464,10'd466,10'd467,
        10'd469,10'd470,10'd471,10'd473,10'd474,10'd476,10'd477,10'd479,
        10'd480,10'd481,10'd483,10'd484,10'd486,10'd487,10'd488,10'd490,
        10'd491,10'd492,10'd494,10'd495,10'd496,10'd498,10'd499,10'd500,
        10'd502,10'd503,10'd504,10'd506,10'd507,10'd508,10'd509,10'd511
    };

endpackage

`default_nettype wire

// ===== rtl/stereo_pan_distance_volume.sv =====
// stereo_pan_distance_volume: left and right volume from camera and sound source positions
// depends on spdv_pkg (volume and arctangent tables, constants)
`timescale 1ns / 1ps
`default_nettype none

// One request at a time: a request is taken when the block is idle, and the two volumes
// appear on the output register once the sequence below is through (it is shorter when a
// bearing is vertical or shallow); the next request can be taken as soon as they appear.
// The sequence runs on one shared subtract-and-compare unit that retires one bit per
// cycle: the square root of the squared distance, and for each of the two bearings a
// ratio division and, for steep bearings, a reciprocal division. The division of the
// distance by 250 is a reciprocal multiplication and is combinational.
// A finished result waits in the output register while the next request is taken.
module stereo_pan_distance_volume
    import spdv_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire signed [COORD_BITS-1:0] i_eye_x,
    input  wire signed [COORD_BITS-1:0] i_eye_y,
    input  wire signed [COORD_BITS-1:0] i_eye_z,
    input  wire signed [COORD_BITS-1:0] i_target_x,
    input  wire signed [COORD_BITS-1:0] i_target_z,
    input  wire signed [COORD_BITS-1:0] i_source_x,
    input  wire signed [COORD_BITS-1:0] i_source_y,
    input  wire signed [COORD_BITS-1:0] i_source_z,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [6:0]                  o_volume_left,
    output logic [6:0]                  o_volume_right
);

    localparam int D  = COORD_BITS + 1;
    localparam int SW = 2 * D + 2;
    localparam int RW = D + 1;
    localparam int NB = (D + FRAC_BITS > RECIP_BITS) ? D + FRAC_BITS : RECIP_BITS;
    localparam int NW = (SW > NB) ? SW : NB;
    localparam int UW = D + 14;
    localparam int CW = $clog2(NW + 1);

    // distance at which the attenuation index saturates (128 steps of 250)
    localparam logic [17:0] SAT_ROOT  = 18'd32000;
    // ceil(2^21 / 125), exact for halved distances below 16000
    localparam logic [14:0] RECIP_125 = 15'd16778;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_ITER = 3'd2;
    localparam logic [2:0] S_BSET = 3'd3;
    localparam logic [2:0] S_BCHK = 3'd4;
    localparam logic [2:0] S_BANG = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // operations of the shared unit
    localparam logic [1:0] OP_SQRT = 2'd0;
    localparam logic [1:0] OP_DIV1 = 2'd2;
    localparam logic [1:0] OP_DIV2 = 2'd3;

    logic [2:0]          r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_b, n_b;
    logic signed [D-1:0] r_hx, n_hx, r_hz, n_hz, r_tx, n_tx, r_tz, n_tz, r_dy, n_dy;
    logic [2*D-1:0]      r_prod, n_prod;
    logic [SW-1:0]       r_acc, n_acc;
    logic [NW-1:0]       r_num, n_num;
    logic [NW-1:0]       r_q, n_q;
    logic [UW-1:0]       r_rem, n_rem;
    logic [UW-1:0]       r_den, n_den;
    logic [6:0]          r_d, n_d;
    logic                r_neg, n_neg, r_dxneg, n_dxneg, r_big, n_big;
    logic [11:0]         r_h, n_h, r_t, n_t;
    logic                r_ovalid, n_ovalid;
    t_vol                r_left, n_left, r_right, n_right;

    // input differences, eye to source and eye to target
    logic signed [D-1:0] dif_hx, dif_hz, dif_tx, dif_tz, dif_dy;
    assign dif_hx = {i_source_x[COORD_BITS-1], i_source_x} - {i_eye_x[COORD_BITS-1], i_eye_x};
    assign dif_hz = {i_source_z[COORD_BITS-1], i_source_z} - {i_eye_z[COORD_BITS-1], i_eye_z};
    assign dif_tx = {i_target_x[COORD_BITS-1], i_target_x} - {i_eye_x[COORD_BITS-1], i_eye_x};
    assign dif_tz = {i_target_z[COORD_BITS-1], i_target_z} - {i_eye_z[COORD_BITS-1], i_eye_z};
    assign dif_dy = {i_source_y[COORD_BITS-1], i_source_y} - {i_eye_y[COORD_BITS-1], i_eye_y};

    // squarer for the distance
    logic signed [D-1:0]   sq_sel;
    logic signed [2*D-1:0] sq_ext;
    logic [2*D-1:0]        sq_res;
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    sq_sel = r_hx;
            2'd1:    sq_sel = r_dy;
            2'd2:    sq_sel = r_hz;
            default: sq_sel = '0;
        endcase
        sq_ext = (2 * D)'(sq_sel);
        sq_res = sq_ext * sq_ext;
    end

    // shared subtract and compare unit: one root or quotient bit per cycle
    logic [UW-1:0] sub_a, sub_b;
    logic [UW:0]   sub_d;
    logic          sub_ge;
    always_comb begin
        if (r_op == OP_SQRT) begin
            sub_a = {r_rem[UW-3:0], r_num[NW-1 -: 2]};
            sub_b = {r_q[UW-3:0], 2'b01};
        end else begin
            sub_a = {r_rem[UW-2:0], r_num[NW-1]};
            sub_b = r_den;
        end
        sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge = !sub_d[UW];
    end

    // distance over 250 by reciprocal multiplication, saturating at 127
    logic [17:0] dd_root;
    logic [13:0] dd_half;
    logic [28:0] dd_prod;
    logic [6:0]  dd_q;
    always_comb begin
        dd_root = 18'(r_q[RW-1:0]);
        dd_half = dd_root[14:1];
        dd_prod = dd_half * RECIP_125;
        dd_q    = (dd_root >= SAT_ROOT) ? 7'h7f : dd_prod[27:21];
    end

    // bearing operands of the current vector
    logic signed [D-1:0] b_dx, b_dz;
    logic [D-1:0]        b_adx, b_adz;
    always_comb begin
        b_dx  = r_b ? r_tx : r_hx;
        b_dz  = r_b ? r_tz : r_hz;
        b_adx = b_dx[D-1] ? D'(-b_dx) : D'(b_dx);
        b_adz = b_dz[D-1] ? D'(-b_dz) : D'(b_dz);
    end

    // arctangent lookup and bearing from the finished quotient
    logic [8:0]  at_idx;
    logic [9:0]  at_val;
    logic [10:0] at_ang;
    logic [11:0] at_base, at_bear;
    always_comb begin
        at_idx  = r_big ? {1'b0, r_q[11:4]} : r_q[12:4];
        at_val  = at_idx[8] ? ATAN_TOP : ATAN_ROM[at_idx[7:0]];
        at_ang  = r_big ? 11'h400 - {1'b0, at_val} : {1'b0, at_val};
        at_base = r_dxneg ? 12'h800 : 12'h000;
        at_bear = r_neg ? at_base + {1'b0, at_ang} : at_base - {1'b0, at_ang};
    end

    // pan selection and attenuation
    function automatic t_vol clamp_vol(input logic [7:0] v, input logic [7:0] a);
        logic [8:0] diff;
        diff = {1'b0, v} - {1'b0, a};
        if (diff[8]) begin
            return '0;
        end else if (diff[7]) begin
            return 7'h7f;
        end
        return diff[6:0];
    endfunction

    logic [11:0] pn_rel;
    logic        pn_centre, pn_right, pn_win, pn_flip;
    logic [7:0]  pn_idx, pn_far, pn_att, pn_lv, pn_rv;
    always_comb begin
        pn_rel    = r_h - r_t;
        pn_centre = (pn_rel == 12'h000) || (pn_rel == 12'h800);
        pn_right  = pn_rel[11];
        pn_win    = (pn_rel >= 12'h401) && (pn_rel <= 12'hbff);
        pn_flip   = pn_win ? !pn_right : pn_right;
        pn_idx    = pn_flip ? NEAR_LEVEL - {1'b0, pn_rel[9:3]} : {1'b0, pn_rel[9:3]};
        pn_far    = VOL_ROM[pn_idx];
        pn_att    = VOL_ROM[{1'b1, r_d}];
        if (pn_centre) begin
            pn_lv = NEAR_LEVEL;
            pn_rv = NEAR_LEVEL;
        end else begin
            pn_lv = pn_right ? pn_far : NEAR_LEVEL;
            pn_rv = pn_right ? NEAR_LEVEL : pn_far;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_cnt    = r_cnt;
        n_b      = r_b;
        n_hx     = r_hx;
        n_hz     = r_hz;
        n_tx     = r_tx;
        n_tz     = r_tz;
        n_dy     = r_dy;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_num    = r_num;
        n_q      = r_q;
        n_rem    = r_rem;
        n_den    = r_den;
        n_d      = r_d;
        n_neg    = r_neg;
        n_dxneg  = r_dxneg;
        n_big    = r_big;
        n_h      = r_h;
        n_t      = r_t;
        n_ovalid = r_ovalid;
        n_left   = r_left;
        n_right  = r_right;

        // result taken downstream
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_hx    = dif_hx;
                    n_hz    = dif_hz;
                    n_tx    = dif_tx;
                    n_tz    = dif_tz;
                    n_dy    = dif_dy;
                    n_prod  = '0;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_prod = sq_res;
                n_acc  = r_acc + SW'(r_prod);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_num   = NW'(r_acc + SW'(r_prod)) << (NW - SW);
                    n_q     = '0;
                    n_rem   = '0;
                    n_op    = OP_SQRT;
                    n_cnt   = CW'(SW / 2);
                    n_state = S_ITER;
                end
            end
            S_ITER: begin
                n_rem = sub_ge ? sub_d[UW-1:0] : sub_a;
                n_q   = {r_q[NW-2:0], sub_ge};
                n_num = (r_op == OP_SQRT) ? r_num << 2 : r_num << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    unique case (r_op)
                        OP_SQRT: begin
                            // root stays in the quotient register for the scaling
                            n_b     = 1'b0;
                            n_state = S_BSET;
                        end
                        OP_DIV1: begin
                            n_state = S_BCHK;
                        end
                        OP_DIV2: begin
                            n_state = S_BANG;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_BSET: begin
                // attenuation index from the root, on the first vector only
                if (!r_b) begin
                    n_d = dd_q;
                end
                n_neg   = b_dx[D-1] ^ b_dz[D-1];
                n_dxneg = b_dx[D-1];
                if (b_dx == '0) begin
                    // vertical bearing
                    if (r_b) begin
                        n_t = (!b_dz[D-1] && (b_dz != '0)) ? 12'hc00 : 12'h400;
                        n_state = S_OUT;
                    end else begin
                        n_h = (!b_dz[D-1] && (b_dz != '0)) ? 12'hc00 : 12'h400;
                        n_b = 1'b1;
                    end
                end else begin
                    n_num   = NW'({b_adz, {FRAC_BITS{1'b0}}}) << (NW - D - FRAC_BITS);
                    n_den   = UW'(b_adx);
                    n_q     = '0;
                    n_rem   = '0;
                    n_op    = OP_DIV1;
                    n_cnt   = CW'(D + FRAC_BITS);
                    n_state = S_ITER;
                end
            end
            S_BCHK: begin
                if (r_q > NW'(UNITY)) begin
                    // steep: take the reciprocal ratio
                    n_big   = 1'b1;
                    n_num   = NW'(1) << (NW - 1);
                    n_den   = UW'(r_q);
                    n_q     = '0;
                    n_rem   = '0;
                    n_op    = OP_DIV2;
                    n_cnt   = CW'(RECIP_BITS);
                    n_state = S_ITER;
                end else begin
                    n_big   = 1'b0;
                    n_state = S_BANG;
                end
            end
            S_BANG: begin
                if (r_b) begin
                    n_t     = at_bear;
                    n_state = S_OUT;
                end else begin
                    n_h     = at_bear;
                    n_b     = 1'b1;
                    n_state = S_BSET;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_left   = clamp_vol(pn_lv, pn_att);
                    n_right  = clamp_vol(pn_rv, pn_att);
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_cnt   <= n_cnt;
        r_b     <= n_b;
        r_hx    <= n_hx;
        r_hz    <= n_hz;
        r_tx    <= n_tx;
        r_tz    <= n_tz;
        r_dy    <= n_dy;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_num   <= n_num;
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_d     <= n_d;
        r_neg   <= n_neg;
        r_dxneg <= n_dxneg;
        r_big   <= n_big;
        r_h     <= n_h;
        r_t     <= n_t;
        r_left  <= n_left;
        r_right <= n_right;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_volume_left  = r_left;
    assign o_volume_right = r_right;

    // a new result is only loaded from the final state
    a_rise_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT)
        else $error("result valid without finishing the sequence");

    // an accepted request starts the squaring pass
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> r_state == S_SQ)
        else $error("accepted request did not start");

    // the reciprocal ratio is always below one
    a_recip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BANG && r_big) |-> r_q < NW'(UNITY))
        else $error("reciprocal ratio out of range");

    // the ratio of a shallow bearing never exceeds one
    a_shallow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BANG && !r_big) |-> r_q <= NW'(UNITY))
        else $error("shallow ratio out of range");

endmodule

`default_nettype wire
